FILE: rtl/mp2_pkg.sv
// mp2_pkg: shared types and constants of the streaming 2-d max pooling block
// no dependencies; imported by the checker, the line memory and the top level
package mp2_pkg;

  localparam int POOLED_BITS  = 16;
  localparam int KERNEL_BITS  = 4;
  localparam int DIM_BITS     = 11;
  localparam int ROW_BITS     = 10;
  localparam int MAX_HEIGHT   = 1024;
  localparam int STEP_BITS    = 4;
  localparam int CFG_IDX_BITS = 2;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_BITS-1:0] CFG_KERNEL = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_STRIDE = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT = 2'd3;

  // values after reset
  localparam logic [KERNEL_BITS-1:0] KERNEL_RST = 4'd2;
  localparam logic [KERNEL_BITS-1:0] STRIDE_RST = 4'd2;
  localparam logic [DIM_BITS-1:0]    WIDTH_RST  = 11'd32;
  localparam logic [DIM_BITS-1:0]    HEIGHT_RST = 11'd32;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_POOL,
    S_ERR
  } pool_state_t;

  typedef enum logic [1:0] {
    CK_IDLE,
    CK_LOAD,
    CK_RUN
  } check_state_t;

  typedef struct packed {
    logic busy;
    logic ok;
  } check_status_t;

endpackage

FILE: rtl/mp2_stream_if.sv
// mp2_stream_if: valid/ready channels for input samples and pooled results
// no dependencies; used by the top level ports
interface mp2_in_if #(parameter int SAMPLE_BITS = 16) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  modport source (output valid, sample, input ready);
  modport sink (input valid, sample, output ready);
endinterface

interface mp2_out_if ();
  logic               valid;
  logic               ready;
  logic signed [15:0] pooled;
  logic               row_end;
  logic               plane_end;
  logic               size_error;
  modport source (output valid, pooled, row_end, plane_end, size_error, input ready);
  modport sink (input valid, pooled, row_end, plane_end, size_error, output ready);
endinterface

FILE: rtl/mp2_cfg_check.sv
// mp2_cfg_check: checks a new configuration, range tests plus bit-serial remainders
// depends on mp2_pkg
module mp2_cfg_check import mp2_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_KERNEL = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [KERNEL_BITS-1:0] win_size,
  input  logic [KERNEL_BITS-1:0] stride,
  input  logic [DIM_BITS-1:0]    image_width,
  input  logic [DIM_BITS-1:0]    image_height,
  output check_status_t          status
);

  check_state_t           state, state_next;
  logic [DIM_BITS-1:0]    dw, dh;
  logic [KERNEL_BITS-1:0] remw, remh, remw_next, remh_next;
  logic [STEP_BITS-1:0]   steps;
  logic                   ok;
  logic                   range_ok;
  logic                   last_step;

  // one restoring division step
  function automatic logic [KERNEL_BITS-1:0] div_step(input logic [KERNEL_BITS-1:0] rem,
                                                      input logic bit_in,
                                                      input logic [KERNEL_BITS-1:0] d);
    logic [KERNEL_BITS:0] sh;
    sh = {rem, bit_in};
    if (sh >= {1'b0, d}) begin
      sh = sh - {1'b0, d};
    end
    return sh[KERNEL_BITS-1:0];
  endfunction

  assign range_ok = (win_size != '0) && (32'(win_size) <= MAX_KERNEL) &&
                    (stride != '0) && (32'(stride) <= MAX_KERNEL) &&
                    (image_width != '0) && (32'(image_width) <= MAX_WIDTH) &&
                    (image_height != '0) && (32'(image_height) <= MAX_HEIGHT) &&
                    (DIM_BITS'(win_size) <= image_width) &&
                    (DIM_BITS'(win_size) <= image_height);

  assign remw_next = div_step(remw, dw[DIM_BITS-1], stride);
  assign remh_next = div_step(remh, dh[DIM_BITS-1], stride);
  assign last_step = (steps == STEP_BITS'(DIM_BITS - 1));

  always_comb begin
    state_next = state;
    case (state)
      CK_IDLE: state_next = CK_IDLE;
      CK_LOAD: state_next = CK_RUN;
      CK_RUN:  state_next = last_step ? CK_IDLE : CK_RUN;
      default: state_next = CK_IDLE;
    endcase
    if (start) begin
      state_next = CK_LOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CK_IDLE;
      ok    <= 1'b1;
    end else begin
      state <= state_next;
      if (state == CK_RUN && last_step && !start) begin
        ok <= range_ok && (remw_next == '0) && (remh_next == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == CK_LOAD) begin
      dw    <= image_width - DIM_BITS'(win_size);
      dh    <= image_height - DIM_BITS'(win_size);
      remw  <= '0;
      remh  <= '0;
      steps <= '0;
    end else if (state == CK_RUN) begin
      dw    <= {dw[DIM_BITS-2:0], 1'b0};
      dh    <= {dh[DIM_BITS-2:0], 1'b0};
      remw  <= remw_next;
      remh  <= remh_next;
      steps <= steps + 1'b1;
    end
  end

  assign status.busy = (state != CK_IDLE);
  assign status.ok   = ok;

endmodule

FILE: rtl/mp2_line_mem.sv
// mp2_line_mem: banked line memory, one bank per kernel row, all banks read at once
// depends on mp2_pkg
module mp2_line_mem import mp2_pkg::*; #(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_KERNEL  = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]         addr,
  input  logic [MAX_KERNEL-1:0]                wr_en,
  input  logic signed [SAMPLE_BITS-1:0]        wr_data,
  output logic signed [SAMPLE_BITS-1:0]        rd_data [MAX_KERNEL]
);

  for (genvar b = 0; b < MAX_KERNEL; b++) begin : g_bank
    logic signed [SAMPLE_BITS-1:0] mem [MAX_WIDTH];

    always_ff @(posedge clk) begin
      if (wr_en[b]) begin
        mem[addr] <= wr_data;
      end
      if (rd_en) begin
        rd_data[b] <= mem[addr];
      end
    end
  end

endmodule

FILE: rtl/max_pool_2d_stream_core.sv
// max_pool_2d_stream_core: a result passes S_READ and S_POOL, a size error S_ERR
// a new sample is taken only in S_IDLE, once the previous one has passed the
// read-then-write of the banked line memory and the column maxima combine
// a configuration write stalls input while the stride check runs
// synchronous active-high reset: registers to 2/2/32/32, position to row 0 column 0
// depends on mp2_pkg, mp2_stream_if, mp2_cfg_check, mp2_line_mem
module max_pool_2d_stream_core import mp2_pkg::*; #(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_KERNEL  = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  mp2_in_if.sink                  in_ch,
  mp2_out_if.source               out_ch,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [DIM_BITS-1:0]     cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int BW = $clog2(MAX_KERNEL);

  // configuration registers
  logic [KERNEL_BITS-1:0] win_size, stride;
  logic [DIM_BITS-1:0]    image_width, image_height;
  check_status_t          ck_stat;

  // position in the plane
  logic [CW-1:0]       column_count;
  logic [ROW_BITS-1:0] row_count;
  logic [BW-1:0]       column_phase, row_phase;
  logic [BW-1:0]       row_bank;   // row_count mod MAX_KERNEL
  logic [BW-1:0]       col_slot;   // column_count mod MAX_KERNEL

  pool_state_t state, state_next;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic signed [SAMPLE_BITS-1:0] rd_data [MAX_KERNEL];
  logic signed [SAMPLE_BITS-1:0] col_max [MAX_KERNEL];
  logic signed [SAMPLE_BITS-1:0] colmax_now, best_now;
  logic [MAX_KERNEL-1:0]         bank_we;
  logic [BW-1:0]                 pool_slot;
  logic                          pool_row_end, pool_plane_end;

  logic in_xfer, mem_rd, cm_we, out_load, out_free;
  logic rows_full, cols_full, emit_now, last_col, last_row;

  // output register
  logic                   out_valid;
  logic signed [15:0]     out_pooled;
  logic                   out_row_end, out_plane_end, out_err;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid || out_ch.ready;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      win_size     <= KERNEL_RST;
      stride       <= STRIDE_RST;
      image_width  <= WIDTH_RST;
      image_height <= HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KERNEL: win_size     <= cfg_data[KERNEL_BITS-1:0];
        CFG_STRIDE: stride       <= cfg_data[KERNEL_BITS-1:0];
        CFG_WIDTH:  image_width  <= cfg_data;
        CFG_HEIGHT: image_height <= cfg_data;
        default:    ;
      endcase
    end
  end

  mp2_cfg_check #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_KERNEL (MAX_KERNEL)
  ) u_check (
    .clk          (clk),
    .rst          (rst),
    .start        (cfg_we),
    .win_size     (win_size),
    .stride       (stride),
    .image_width  (image_width),
    .image_height (image_height),
    .status       (ck_stat)
  );

  // ---------------------------------------------------------------- line memory
  mp2_line_mem #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_KERNEL  (MAX_KERNEL),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lines (
    .clk     (clk),
    .rd_en   (mem_rd),
    .addr    (column_count),
    .wr_en   (bank_we),
    .wr_data (sample_q),
    .rd_data (rd_data)
  );

  // window bookkeeping for the sample held in sample_q
  assign rows_full = (32'(row_count) + 1 >= 32'(win_size));
  assign cols_full = (32'(column_count) + 1 >= 32'(win_size));
  assign emit_now  = rows_full && cols_full && (row_phase == '0) && (column_phase == '0);
  assign last_col  = (32'(column_count) + 1 == 32'(image_width));
  assign last_row  = (32'(row_count) + 1 == 32'(image_height));

  // column maximum over the last kernel rows; the current row comes from sample_q
  always_comb begin
    int age;
    colmax_now = sample_q;
    for (int b = 0; b < MAX_KERNEL; b++) begin
      age = (int'(row_bank) >= b) ? int'(row_bank) - b : int'(row_bank) + MAX_KERNEL - b;
      if (age != 0 && age < int'(win_size) && rd_data[b] > colmax_now) begin
        colmax_now = rd_data[b];
      end
    end
  end

  // window maximum over the last kernel column maxima
  always_comb begin
    int age;
    best_now = col_max[pool_slot];
    for (int j = 0; j < MAX_KERNEL; j++) begin
      age = (int'(pool_slot) >= j) ? int'(pool_slot) - j : int'(pool_slot) + MAX_KERNEL - j;
      if (age < int'(win_size) && col_max[j] > best_now) begin
        best_now = col_max[j];
      end
    end
  end

  // ---------------------------------------------------------------- control
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          state_next = ck_stat.ok ? S_READ : S_ERR;
        end
      end
      S_READ: state_next = emit_now ? S_POOL : S_IDLE;
      S_POOL: state_next = out_free ? S_IDLE : S_POOL;
      S_ERR:  state_next = out_free ? S_IDLE : S_ERR;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = (state == S_IDLE) && !ck_stat.busy;
    mem_rd      = in_xfer && ck_stat.ok;
    cm_we       = (state == S_READ) && rows_full;
    out_load    = (state == S_POOL || state == S_ERR) && out_free;
    bank_we     = '0;
    if (state == S_READ) begin
      bank_we[row_bank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      sample_q <= in_ch.sample;
    end
    if (cm_we) begin
      col_max[col_slot] <= colmax_now;
    end
    if (state == S_READ) begin
      pool_slot      <= col_slot;
      pool_row_end   <= last_col;
      pool_plane_end <= last_col && last_row;
    end
  end

  // position advance once the sample is in the line memory
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      column_count <= '0;
      row_count    <= '0;
      column_phase <= '0;
      row_phase    <= '0;
      row_bank     <= '0;
      col_slot     <= '0;
    end else if (state == S_READ) begin
      if (last_col) begin
        column_count <= '0;
        column_phase <= '0;
        col_slot     <= '0;
        if (last_row) begin
          row_count <= '0;
          row_phase <= '0;
          row_bank  <= '0;
        end else begin
          row_count <= row_count + 1'b1;
          row_bank  <= (32'(row_bank) == MAX_KERNEL - 1) ? '0 : row_bank + 1'b1;
          if (rows_full) begin
            row_phase <= (32'(row_phase) + 1 >= 32'(stride)) ? '0 : row_phase + 1'b1;
          end
        end
      end else begin
        column_count <= column_count + 1'b1;
        col_slot     <= (32'(col_slot) == MAX_KERNEL - 1) ? '0 : col_slot + 1'b1;
        if (cols_full) begin
          column_phase <= (32'(column_phase) + 1 >= 32'(stride)) ? '0 : column_phase + 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == S_ERR) begin
        out_pooled    <= '0;
        out_row_end   <= 1'b0;
        out_plane_end <= 1'b0;
        out_err       <= 1'b1;
      end else begin
        out_pooled    <= POOLED_BITS'(best_now);
        out_row_end   <= pool_row_end;
        out_plane_end <= pool_plane_end;
        out_err       <= 1'b0;
      end
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.pooled     = out_pooled;
  assign out_ch.row_end    = out_row_end;
  assign out_ch.plane_end  = out_plane_end;
  assign out_ch.size_error = out_err;

  // ---------------------------------------------------------------- checks
  a_no_xfer_while_checking: assert property (@(posedge clk) disable iff (rst)
    in_xfer |-> !ck_stat.busy)
    else $error("input transfer during configuration check");

  a_good_xfer_reads: assert property (@(posedge clk) disable iff (rst)
    in_xfer && ck_stat.ok |=> state == S_READ)
    else $error("accepted sample did not reach the memory read");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_err |-> !out_row_end && !out_plane_end && out_pooled == '0)
    else $error("error result carries data");

  a_plane_implies_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_plane_end |-> out_row_end)
    else $error("plane end without row end");

endmodule

FILE: tb/max_pool_2d_stream_core_tb.sv
// max_pool_2d_stream_core_tb: self-checking bench for the streaming 2-d max pooling core
// directed table then random planes over many window/stride/size settings
// depends on mp2_pkg, mp2_stream_if and max_pool_2d_stream_core
module max_pool_2d_stream_core_tb;
  import mp2_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXW = 1024;
  localparam int MAXK = 8;
  localparam int CYCLE_LIMIT = 600000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = CFG_KERNEL;
  logic [DIM_BITS-1:0] cfg_data = '0;

  mp2_in_if #(.SAMPLE_BITS(16)) in_ch ();
  mp2_out_if out_ch ();

  max_pool_2d_stream_core #(.MAX_WIDTH(MAXW), .MAX_KERNEL(MAXK), .SAMPLE_BITS(16)) uut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one pooled result as it appears on the output channel
  typedef struct {
    logic signed [15:0] pooled;
    logic row_end;
    logic plane_end;
    logic size_error;
  } pool_result_t;

  // one row of the directed table: a register write or a sample transfer
  typedef struct {
    bit is_cfg;
    logic [CFG_IDX_BITS-1:0] idx;
    logic [DIM_BITS-1:0] data;
    logic signed [15:0] sample;
    bit typed;
    pool_result_t res;
  } dir_row_t;

  pool_result_t pending_results[$];
  dir_row_t dir_rows[$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 1'b0;

  // predictor copy of registers and position
  logic [3:0] p_kernel = KERNEL_RST;
  logic [3:0] p_stride = STRIDE_RST;
  logic [10:0] p_width = WIDTH_RST;
  logic [10:0] p_height = HEIGHT_RST;
  logic signed [15:0] lines [MAXK*MAXW];
  logic signed [15:0] col_max [MAXK];
  int col_cnt = 0, row_cnt = 0, col_ph = 0, row_ph = 0;

  function automatic bit sizes_bad();
    int k, s, w, h;
    k = p_kernel; s = p_stride; w = p_width; h = p_height;
    if (k == 0 || k > MAXK || s == 0 || s > MAXK) return 1'b1;
    if (w == 0 || w > MAXW || h == 0 || h > MAX_HEIGHT) return 1'b1;
    if (k > w || k > h) return 1'b1;
    return ((w - k) % s != 0) || ((h - k) % s != 0);
  endfunction

  // advance the pooling position by one sample; returns 1 for a window or size error
  function automatic bit pool_sample(input logic signed [15:0] x, output pool_result_t r);
    int k, s, c, rr;
    logic signed [15:0] best, v, cm;
    bit emit, last_c, last_r;
    k = p_kernel; s = p_stride; c = col_cnt; rr = row_cnt;
    emit = 1'b0;
    best = '0;
    r = '{pooled: '0, row_end: 1'b0, plane_end: 1'b0, size_error: 1'b0};
    if (sizes_bad()) begin
      r.size_error = 1'b1;
      return 1'b1;
    end
    lines[(rr % MAXK) * MAXW + c] = x;
    if (rr + 1 >= k) begin
      cm = x;
      for (int m = 1; m < k; m++) begin
        v = lines[((rr - m) % MAXK) * MAXW + c];
        if (v > cm) cm = v;
      end
      col_max[c % MAXK] = cm;
      if (c + 1 >= k && row_ph == 0 && col_ph == 0) begin
        best = col_max[c % MAXK];
        for (int m = 1; m < k; m++) begin
          v = col_max[(c - m) % MAXK];
          if (v > best) best = v;
        end
        emit = 1'b1;
      end
    end
    last_c = (c + 1 == p_width);
    last_r = (rr + 1 == p_height);
    if (c + 1 >= k) col_ph = (col_ph + 1 >= s) ? 0 : col_ph + 1;
    if (last_c) begin
      col_cnt = 0;
      col_ph = 0;
      if (rr + 1 >= k) row_ph = (row_ph + 1 >= s) ? 0 : row_ph + 1;
      if (last_r) begin
        row_cnt = 0; row_ph = 0;
      end else begin
        row_cnt = rr + 1;
      end
    end else begin
      col_cnt = c + 1;
    end
    r.pooled = best;
    r.row_end = last_c;
    r.plane_end = last_c && last_r;
    return emit;
  endfunction

  // register write, only once the block has gone quiet
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [DIM_BITS-1:0] d);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_KERNEL: p_kernel = d[3:0];
      CFG_STRIDE: p_stride = d[3:0];
      CFG_WIDTH:  p_width = d;
      default:    p_height = d;
    endcase
    col_cnt = 0; row_cnt = 0; col_ph = 0; row_ph = 0;
  endtask

  // one sample transfer; typed expectations override the predicted one
  // valid stays high on return so samples can follow back to back
  task automatic send_sample(input logic signed [15:0] x, input bit typed, input pool_result_t t);
    pool_result_t r;
    bit has;
    while (!quiet && $urandom_range(99) < 10) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample <= x;
    do @(posedge clk); while (!in_ch.ready);
    has = pool_sample(x, r);
    if (typed) pending_results = {pending_results, t};
    else if (has) pending_results = {pending_results, r};
    @(negedge clk);
  endtask

  task automatic add_cfg(input logic [CFG_IDX_BITS-1:0] idx, input logic [DIM_BITS-1:0] d);
    dir_row_t row;
    row = '{is_cfg: 1'b1, idx: idx, data: d, sample: '0, typed: 1'b0,
            res: '{pooled: '0, row_end: 1'b0, plane_end: 1'b0, size_error: 1'b0}};
    dir_rows = {dir_rows, row};
  endtask

  task automatic add_smp(input logic signed [15:0] x, input bit typed,
                         input logic signed [15:0] p, input bit re, input bit pe, input bit er);
    dir_row_t row;
    row = '{is_cfg: 1'b0, idx: CFG_KERNEL, data: '0, sample: x, typed: typed,
            res: '{pooled: p, row_end: re, plane_end: pe, size_error: er}};
    dir_rows = {dir_rows, row};
  endtask

  // result ready, with a quiet stretch
  always @(negedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= quiet || ($urandom_range(99) >= 10);
  end

  // compare every result transfer with the oldest expectation
  always @(posedge clk) begin
    pool_result_t e;
    cycles <= cycles + 1;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result pooled=%0d", out_ch.pooled);
      end else begin
        e = pending_results.pop_front();
        if (out_ch.pooled !== e.pooled || out_ch.row_end !== e.row_end ||
            out_ch.plane_end !== e.plane_end || out_ch.size_error !== e.size_error) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp %0d/%0b/%0b/%0b got %0d/%0b/%0b/%0b",
                     e.pooled, e.row_end, e.plane_end, e.size_error, out_ch.pooled,
                     out_ch.row_end, out_ch.plane_end, out_ch.size_error);
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    pool_result_t none;
    int sent, k, s, w, h, n;
    none = '{pooled: '0, row_end: 1'b0, plane_end: 1'b0, size_error: 1'b0};
    in_ch.valid = 1'b0;
    in_ch.sample = '0;

    // 1x1 windows on a 2x2 plane: each sample comes straight back
    add_cfg(CFG_KERNEL, 11'd1); add_cfg(CFG_STRIDE, 11'd1);
    add_cfg(CFG_WIDTH, 11'd2); add_cfg(CFG_HEIGHT, 11'd2);
    add_smp(-16'sd32768, 1, -16'sd32768, 0, 0, 0);
    add_smp(16'sd32767, 1, 16'sd32767, 1, 0, 0);
    add_smp(16'sd0, 1, 16'sd0, 0, 0, 0);
    add_smp(-16'sd1, 1, -16'sd1, 1, 1, 0);
    // width beyond the line memory, then zero width
    add_cfg(CFG_WIDTH, 11'h7FF); add_smp(16'sd5, 1, 0, 0, 0, 1);
    add_cfg(CFG_WIDTH, 11'd0); add_smp(-16'sd5, 1, 0, 0, 0, 1);
    // stride does not divide the leftover
    add_cfg(CFG_KERNEL, 11'd3); add_cfg(CFG_STRIDE, 11'd2);
    add_cfg(CFG_WIDTH, 11'd4); add_cfg(CFG_HEIGHT, 11'd3);
    add_smp(16'sd7, 1, 0, 0, 0, 1);
    add_cfg(CFG_KERNEL, 11'd9); add_smp(16'sd1, 1, 0, 0, 0, 1);
    add_cfg(CFG_KERNEL, 11'd0); add_smp(16'sd1, 1, 0, 0, 0, 1);
    add_cfg(CFG_KERNEL, 11'd1); add_cfg(CFG_STRIDE, 11'd0); add_smp(16'sd1, 1, 0, 0, 0, 1);
    add_cfg(CFG_STRIDE, 11'd9); add_smp(16'sd1, 1, 0, 0, 0, 1);
    // kernel larger than the image, zero height, too tall
    add_cfg(CFG_STRIDE, 11'd1); add_cfg(CFG_KERNEL, 11'd8); add_smp(16'sd2, 1, 0, 0, 0, 1);
    add_cfg(CFG_KERNEL, 11'd1); add_cfg(CFG_HEIGHT, 11'd0); add_smp(16'sd2, 1, 0, 0, 0, 1);
    add_cfg(CFG_HEIGHT, 11'd1025); add_smp(16'sd2, 1, 0, 0, 0, 1);
    // upper register bits dropped: kernel 2, stride 1 on 3x2
    add_cfg(CFG_KERNEL, 11'h7F2); add_cfg(CFG_STRIDE, 11'h7F1);
    add_cfg(CFG_WIDTH, 11'd3); add_cfg(CFG_HEIGHT, 11'd2);
    for (int i = 0; i < 6; i++) add_smp(16'(i * 1000 - 3000), 0, 0, 0, 0, 0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // defaults after reset: 2x2 windows, stride 2 on 32x32
    for (int i = 0; i < 70; i++) send_sample(16'($urandom), 0, none);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_reg(dir_rows[i].idx, dir_rows[i].data);
      else send_sample(dir_rows[i].sample, dir_rows[i].typed, dir_rows[i].res);
    end

    // widest plane with 1x1 windows
    write_reg(CFG_KERNEL, 11'd1); write_reg(CFG_STRIDE, 11'd1);
    write_reg(CFG_WIDTH, 11'd1024); write_reg(CFG_HEIGHT, 11'd1);
    for (int i = 0; i < 1024; i++) send_sample(16'($urandom), 0, none);
    // largest window and stride
    write_reg(CFG_KERNEL, 11'd8); write_reg(CFG_STRIDE, 11'd8);
    write_reg(CFG_WIDTH, 11'd16); write_reg(CFG_HEIGHT, 11'd16);
    for (int i = 0; i < 256; i++) send_sample(16'($urandom), 0, none);

    sent = 0;
    while (sent < 450) begin
      if ($urandom_range(99) < 20) begin
        // raw register values, mostly unusable
        k = $urandom_range(2047); s = $urandom_range(2047);
        w = $urandom_range(2047); h = $urandom_range(2047);
        n = 15;
      end else begin
        k = $urandom_range(1, 8); s = $urandom_range(1, 8);
        w = k + s * $urandom_range(0, 40 / s);
        h = k + s * $urandom_range(0, 16 / s);
        n = w * h * $urandom_range(1, 2) + $urandom_range(0, 5);
        if (n > 400) n = 400;
      end
      write_reg(CFG_KERNEL, 11'(k)); write_reg(CFG_STRIDE, 11'(s));
      write_reg(CFG_WIDTH, 11'(w)); write_reg(CFG_HEIGHT, 11'(h));
      for (int i = 0; i < n; i++) begin
        quiet = (sent >= 150 && sent < 300);
        case ($urandom_range(9))
          0: send_sample(-16'sd32768, 0, none);
          1: send_sample(16'sd32767, 0, none);
          default: send_sample(16'($urandom), 0, none);
        endcase
        sent++;
      end
    end
    in_ch.valid <= 1'b0;
    quiet = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
